@@ design/kbsle_pkg.sv @@
// ----------------------------------------------------------------------------
// kbsle_pkg
// Shared types, codes and the set-1 key code to ASCII map for the line editor.
// ----------------------------------------------------------------------------
package kbsle_pkg;

  // Operation selector carried on the input tuser.
  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result kind carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  localparam logic [7:0] KEY_LSHIFT_PRESS   = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT_PRESS   = 8'h36;
  localparam logic [7:0] KEY_LSHIFT_RELEASE = 8'hAA;
  localparam logic [7:0] KEY_RSHIFT_RELEASE = 8'hB6;

  localparam logic [7:0] CH_NONE = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Field positions inside the output tdata.
  localparam int OUT_DATA_LSB  = 0;
  localparam int OUT_READY_BIT = 8;
  localparam int OUT_LEN_LSB   = 9;

  // Maps a press code to ASCII. Unmapped codes return CH_NONE.
  function automatic logic [7:0] key_to_ascii(input logic [6:0] code, input logic shift);
    logic [7:0] ch;
    unique case (code)
      7'h02: ch = shift ? "!" : "1";
      7'h03: ch = shift ? "@" : "2";
      7'h04: ch = shift ? "#" : "3";
      7'h05: ch = shift ? "$" : "4";
      7'h06: ch = shift ? "%" : "5";
      7'h07: ch = shift ? "^" : "6";
      7'h08: ch = shift ? "&" : "7";
      7'h09: ch = shift ? "*" : "8";
      7'h0A: ch = shift ? "(" : "9";
      7'h0B: ch = shift ? ")" : "0";
      7'h0C: ch = shift ? "_" : "-";
      7'h0D: ch = shift ? "+" : "=";
      7'h0E: ch = CH_BS;
      7'h10: ch = shift ? "Q" : "q";
      7'h11: ch = shift ? "W" : "w";
      7'h12: ch = shift ? "E" : "e";
      7'h13: ch = shift ? "R" : "r";
      7'h14: ch = shift ? "T" : "t";
      7'h15: ch = shift ? "Y" : "y";
      7'h16: ch = shift ? "U" : "u";
      7'h17: ch = shift ? "I" : "i";
      7'h18: ch = shift ? "O" : "o";
      7'h19: ch = shift ? "P" : "p";
      7'h1C: ch = CH_LF;
      7'h1E: ch = shift ? "A" : "a";
      7'h1F: ch = shift ? "S" : "s";
      7'h20: ch = shift ? "D" : "d";
      7'h21: ch = shift ? "F" : "f";
      7'h22: ch = shift ? "G" : "g";
      7'h23: ch = shift ? "H" : "h";
      7'h24: ch = shift ? "J" : "j";
      7'h25: ch = shift ? "K" : "k";
      7'h26: ch = shift ? "L" : "l";
      7'h2C: ch = shift ? "Z" : "z";
      7'h2D: ch = shift ? "X" : "x";
      7'h2E: ch = shift ? "C" : "c";
      7'h2F: ch = shift ? "V" : "v";
      7'h30: ch = shift ? "B" : "b";
      7'h31: ch = shift ? "N" : "n";
      7'h32: ch = shift ? "M" : "m";
      7'h33: ch = shift ? "<" : ",";
      7'h34: ch = shift ? ">" : ".";
      7'h35: ch = shift ? "?" : "/";
      7'h39: ch = " ";
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ design/kbsle_ram.sv @@
// ----------------------------------------------------------------------------
// kbsle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kbsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/keyboard_scancode_line_editor_unit.sv @@
// ----------------------------------------------------------------------------
// keyboard_scancode_line_editor_unit
// Set-1 key code line editor with shift tracking, echo and a line store.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): each transaction is one operation. tuser selects
//   a key code, a read of one stored line character, or a line clear.
//   Output stream (m_axis_*): echo bytes, read replies and clear acknowledges.
//   tlast marks the final result caused by one input transaction.
// Datapath: the decode register is loaded at the accepting edge, together with
//   the registered read of the line store. The output register is loaded
//   from the decode register once it is empty or its result is taken, and
//   only then is the result offered on m_axis.
// Throughput: one input transaction per cycle while the output is not stalled.
//   Enter produces two results (CR then LF) and holds the decode register
//   until both are sent; every other operation produces at most one result.
//   The rate is set by the single output beat per cycle of the output register.
// Reset: rst clears shift state, line length, line-ready flag and all valid
//   flags. The line store itself is not cleared; only written positions below
//   the current length are ever read back.
// Stall: when m_axis_tready is low the output register holds its result and
//   the decode register keeps the next one, so one further transaction is
//   still taken before s_axis_tready drops.
// ----------------------------------------------------------------------------
module keyboard_scancode_line_editor_unit
  import kbsle_pkg::*;
#(
  parameter int LINE_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] key_code, [15:8] read_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data, [8] line_ready, [16:9] line_length
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  // Position width: the line holds at most LINE_CAPACITY-1 characters.
  localparam int PW = $clog2(LINE_CAPACITY);
  // Compare width wide enough for both the position and an 8-bit index.
  localparam int CW = (PW > 8) ? PW : 8;

  // --------------------------------------------------------------------------
  // Editor state.
  // --------------------------------------------------------------------------
  logic          shift_held, shift_held_next;
  logic [PW-1:0] line_pos, line_pos_next;
  logic          line_done, line_done_next;

  // Input transaction fields.
  logic          accept;
  logic [7:0]    key_code;
  logic [7:0]    read_index;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] pos_next_ext;
  logic [7:0]    ch;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign key_code   = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[15:8];
  assign idx_ext    = CW'(read_index);
  assign pos_ext    = CW'(line_pos);
  assign ch         = key_to_ascii(key_code[6:0], shift_held);

  // Decode results for the accepted transaction.
  logic          gen;        // at least one result
  logic          gen_two;    // Enter: CR then LF
  logic          gen_read;   // reply data comes from the line store
  logic          gen_rd_ok;  // index lies inside the current line
  kind_t         gen_kind;
  logic [7:0]    gen_data;
  logic          st_wr_en;
  logic          st_rd_en;

  always_comb begin
    shift_held_next = shift_held;
    line_pos_next   = line_pos;
    line_done_next  = line_done;
    gen             = 1'b0;
    gen_two         = 1'b0;
    gen_read        = 1'b0;
    gen_rd_ok       = 1'b0;
    gen_kind        = KIND_ECHO;
    gen_data        = CH_NONE;
    st_wr_en        = 1'b0;
    st_rd_en        = 1'b0;
    if (accept) begin
      unique case (op_t'(s_axis_tuser))
        OP_READ: begin
          gen       = 1'b1;
          gen_read  = 1'b1;
          gen_kind  = KIND_READ;
          gen_rd_ok = idx_ext < pos_ext;
          st_rd_en  = 1'b1;
        end
        OP_CLEAR: begin
          gen            = 1'b1;
          gen_kind       = KIND_CLEAR;
          line_pos_next  = '0;
          line_done_next = 1'b0;
        end
        OP_KEY: begin
          priority if (key_code == KEY_LSHIFT_PRESS || key_code == KEY_RSHIFT_PRESS) begin
            shift_held_next = 1'b1;
          end else if (key_code == KEY_LSHIFT_RELEASE ||
                       key_code == KEY_RSHIFT_RELEASE) begin
            shift_held_next = 1'b0;
          end else if (key_code[7]) begin
            // Any other release code is ignored.
          end else if (ch == CH_NONE) begin
            // Unmapped press: nothing happens.
          end else if (ch == CH_BS) begin
            gen      = 1'b1;
            gen_data = CH_BS;
            if (line_pos != '0) begin
              line_pos_next = line_pos - PW'(1);
            end
          end else if (ch == CH_LF) begin
            gen            = 1'b1;
            gen_two        = 1'b1;
            line_done_next = 1'b1;
          end else if (line_pos != PW'(LINE_CAPACITY - 1)) begin
            gen           = 1'b1;
            gen_data      = ch;
            st_wr_en      = 1'b1;
            line_pos_next = line_pos + PW'(1);
          end else begin
            // Line full: the character is dropped.
          end
        end
        default: begin
          // Unused operation code: no result and no state change.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      line_pos   <= '0;
      line_done  <= 1'b0;
    end else begin
      shift_held <= shift_held_next;
      line_pos   <= line_pos_next;
      line_done  <= line_done_next;
    end
  end

  // --------------------------------------------------------------------------
  // Line store. A read and a write come from different operations, so they
  // never share a cycle and never collide; a write goes to the current length.
  // --------------------------------------------------------------------------
  logic [7:0] st_rd_data;

  kbsle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (line_pos),
    .wr_data (ch),
    .rd_en   (st_rd_en),
    .rd_addr (idx_ext[PW-1:0]),
    .rd_data (st_rd_data)
  );

  // --------------------------------------------------------------------------
  // Decode register: holds the pending results of one transaction together
  // with the line status after that transaction.
  // --------------------------------------------------------------------------
  logic       p_valid;
  logic       p_beat;     // first of two beats already sent
  logic       p_two;
  logic       p_read;
  logic       p_rd_ok;
  kind_t      p_kind;
  logic [7:0] p_data;
  logic       p_ready;
  logic [7:0] p_len;
  logic       p_send;
  logic       p_final;
  logic [7:0] len_sat;

  assign pos_next_ext = CW'(line_pos_next);
  assign len_sat      = (pos_next_ext > CW'(255)) ? 8'hFF : pos_next_ext[7:0];

  assign p_final       = !p_two || p_beat;
  assign p_send        = p_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !p_valid || (p_send && p_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_beat  <= 1'b0;
    end else if (accept) begin
      p_valid <= gen;
      p_beat  <= 1'b0;
    end else if (p_send) begin
      if (p_final) begin
        p_valid <= 1'b0;
      end else begin
        p_beat <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_two   <= gen_two;
      p_read  <= gen_read;
      p_rd_ok <= gen_rd_ok;
      p_kind  <= gen_kind;
      p_data  <= gen_data;
      p_ready <= line_done_next;
      p_len   <= len_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. The store read data is stable while the decode register
  // holds a read, because no new transaction is taken until it leaves.
  // --------------------------------------------------------------------------
  logic [7:0] beat_data;

  always_comb begin
    priority if (p_read) begin
      beat_data = p_rd_ok ? st_rd_data : CH_NONE;
    end else if (p_two) begin
      beat_data = p_beat ? CH_LF : CH_CR;
    end else begin
      beat_data = p_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p_send) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_send) begin
      m_axis_tdata <= {7'd0, p_len, p_ready, beat_data};
      m_axis_tuser <= p_kind;
      m_axis_tlast <= p_final;
    end
  end

endmodule

@@ design/kbsle_checker.sv @@
// ----------------------------------------------------------------------------
// kbsle_checker
// Port-level checks for the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module kbsle_checker
  import kbsle_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A clear acknowledge reports an empty, not-ready line and ends its input.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_CLEAR |->
      m_axis_tlast && m_axis_tdata[OUT_READY_BIT] == 1'b0 &&
      m_axis_tdata[OUT_LEN_LSB +: 8] == 8'd0 && m_axis_tdata[OUT_DATA_LSB +: 8] == 8'd0)
    else $error("bad clear acknowledge");

  // CR is only echoed as the first half of Enter, with the line ready.
  a_cr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_ECHO &&
      m_axis_tdata[OUT_DATA_LSB +: 8] == CH_CR |->
      !m_axis_tlast && m_axis_tdata[OUT_READY_BIT])
    else $error("CR echo malformed");

  // A taken CR is followed by the LF of the same Enter.
  a_cr_lf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_ECHO &&
      m_axis_tdata[OUT_DATA_LSB +: 8] == CH_LF)
    else $error("LF does not follow CR");

endmodule

bind keyboard_scancode_line_editor_unit kbsle_checker u_kbsle_checker (.*);
